@@ sv/rgb_3x3_convolution_sharpen_defines.svh @@
// Assertion macros shared by the sharpening filter RTL.
// No dependencies; included by the files that carry assertions.
`ifndef RGB_3X3_CONVOLUTION_SHARPEN_DEFINES_SVH
`define RGB_3X3_CONVOLUTION_SHARPEN_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define RGB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed in the next cycle by a consequence.
`define RGB_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

@@ sv/rgb_pkg.sv @@
// Shared types and constants of the sharpening filter.
// No dependencies; used by the front end, the back end, the top level and the testbench.
package rgb_pkg;

  localparam int RGB_MAX_WIDTH  = 1024;
  localparam int HEIGHT_LIMIT   = 4096;
  localparam int MID_DEPTH      = 4;
  localparam int OUT_DEPTH      = 8;

  localparam logic [23:0] KTOP_RESET = 24'd65793;
  localparam logic [23:0] KMID_RESET = 24'd129281;
  localparam logic [23:0] KBOT_RESET = 24'd65793;
  localparam logic [10:0] WIDTH_RESET  = 11'd256;
  localparam logic [12:0] HEIGHT_RESET = 13'd256;

  typedef enum logic [2:0] {
    REG_KTOP   = 3'd0,
    REG_KMID   = 3'd1,
    REG_KBOT   = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } reg_idx_t;

  localparam logic MODE_FLUSH = 1'b1;

  // Per-word control decided by the front end.
  typedef struct packed {
    logic emit;
    logic last;
    logic drop_top;
    logic drop_bottom;
    logic drop_left;
    logic drop_right;
  } flags_t;

endpackage

@@ sv/rgb_q.sv @@
// Small synchronous FIFO built from registers.
// Depends on the assertion macro header.
`include "rgb_3x3_convolution_sharpen_defines.svh"
module rgb_q #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [W-1:0]             wdata,
  input  logic                     pop,
  output logic [W-1:0]             rdata,
  output logic [$clog2(DEPTH):0]   count,
  output logic                     full,
  output logic                     empty
);
  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign rdata = mem_r[rd_ptr_r];
  assign count = count_r;
  assign full  = (count_r == (PW+1)'(DEPTH));
  assign empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  `RGB_ASSERT_ALWAYS(a_no_overflow, !(push && full && !pop), "push into full queue")
  `RGB_ASSERT_ALWAYS(a_no_underflow, !(pop && empty), "pop from empty queue")
  `RGB_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1, "count slip")
endmodule

@@ sv/rgb_fe.sv @@
// Front end: accepts words, tracks input and output raster position, classifies.
// Depends on rgb_pkg.
module rgb_fe #(
  parameter int MAX_WIDTH = rgb_pkg::RGB_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] w_eff,
  input  logic [12:0]                    h_eff,
  input  logic                           accept,
  input  logic                           mode,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  output logic                           q_push,
  output logic [23:0]                    q_pix,
  output logic [$clog2(MAX_WIDTH)-1:0]   q_col,
  output rgb_pkg::flags_t                q_flags
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH+1);

  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [12:0]   in_row_r, in_row_nxt;
  logic [11:0]   out_row_r, out_row_nxt;
  logic          draining, ignore, emit, last;
  logic [WW-1:0] ic_inc, oc_inc;

  always_comb begin
    draining = (in_row_r >= h_eff);
    ignore   = (mode == rgb_pkg::MODE_FLUSH) && !draining;
    emit     = (in_row_r >= 13'd2) || (in_row_r == 13'd1 && in_col_r != '0);
    ic_inc   = WW'(in_col_r) + 1'b1;
    oc_inc   = WW'(out_col_r) + 1'b1;
    last     = emit && ((13'(out_row_r) + 13'd1) >= h_eff) && (oc_inc >= w_eff);

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (accept && !ignore) begin
      if (ic_inc >= w_eff) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 13'd1;
      end else begin
        in_col_nxt = CW'(ic_inc);
      end
      if (last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (emit) begin
        if (oc_inc >= w_eff) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 12'd1;
        end else begin
          out_col_nxt = CW'(oc_inc);
        end
      end
    end

    q_push              = accept && !ignore;
    q_pix               = draining ? 24'd0 : {red, green, blue};
    q_col               = in_col_r;
    q_flags.emit        = emit;
    q_flags.last        = last;
    q_flags.drop_top    = (out_row_r == '0);
    q_flags.drop_bottom = (13'(out_row_r) + 13'd1) >= h_eff;
    q_flags.drop_left   = (out_col_r == '0);
    q_flags.drop_right  = (oc_inc >= w_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end
endmodule

@@ sv/rgb_be.sv @@
// Back end: line buffers, 3x3 window, products and clamped sums.
// Depends on rgb_pkg.
module rgb_be #(
  parameter int MAX_WIDTH = rgb_pkg::RGB_MAX_WIDTH,
  parameter int ODEPTH = rgb_pkg::OUT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [23:0]                  ktop,
  input  logic [23:0]                  kmid,
  input  logic [23:0]                  kbot,
  input  logic                         mq_empty,
  input  logic [23:0]                  mq_pix,
  input  logic [$clog2(MAX_WIDTH)-1:0] mq_col,
  input  rgb_pkg::flags_t              mq_flags,
  output logic                         mq_pop,
  input  logic [$clog2(ODEPTH):0]      oq_count,
  output logic                         oq_push,
  output logic [24:0]                  oq_data
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int NW = $clog2(ODEPTH) + 2;

  logic [23:0] above_r [MAX_WIDTH];
  logic [23:0] two_r   [MAX_WIDTH];
  logic [23:0] rd1_r, rd2_r, byp_d_r, a2;
  logic        byp_r;

  logic            s1_v_r, s2_v_r, s3_v_r;
  logic [CW-1:0]   s1_col_r;
  logic [23:0]     s1_pix_r;
  rgb_pkg::flags_t s1_f_r, s2_f_r, s3_f_r;
  logic [23:0]     win_r [9];
  logic signed [16:0] prod_r [9][3];
  logic [NW-1:0]   inflight;

  // Credit check keeps every word in flight sure of a queue slot.
  always_comb begin
    inflight = NW'(s1_v_r & s1_f_r.emit) + NW'(s2_v_r & s2_f_r.emit)
             + NW'(s3_v_r & s3_f_r.emit);
    mq_pop = !mq_empty && ((NW'(oq_count) + inflight) < NW'(ODEPTH));
  end

  always_ff @(posedge clk) begin
    if (mq_pop) begin
      rd1_r          <= above_r[mq_col];
      above_r[mq_col] <= mq_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (mq_pop) begin
      rd2_r <= two_r[mq_col];
    end
    if (s1_v_r) begin
      two_r[s1_col_r] <= rd1_r;
    end
  end

  // A write to the older line in the same cycle as a read of the same entry.
  always_ff @(posedge clk) begin
    byp_d_r <= rd1_r;
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= mq_pop && s1_v_r && (s1_col_r == mq_col);
    end
  end

  assign a2 = byp_r ? byp_d_r : rd2_r;

  always_ff @(posedge clk) begin
    if (mq_pop) begin
      s1_col_r <= mq_col;
      s1_pix_r <= mq_pix;
      s1_f_r   <= mq_flags;
    end
    if (s1_v_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= a2;
      win_r[5] <= rd1_r;
      win_r[8] <= s1_pix_r;
      s2_f_r   <= s1_f_r;
    end
    if (s2_v_r) begin
      s3_f_r <= s2_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= mq_pop;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Taps outside the image use a zero sample, so stale or unwritten line
  // buffer entries never reach a sum.
  always_ff @(posedge clk) begin
    logic [23:0] krow;
    logic signed [7:0] k;
    logic signed [8:0] p;
    logic en;
    if (s2_v_r) begin
      for (int r = 0; r < 3; r++) begin
        krow = (r == 0) ? ktop : ((r == 1) ? kmid : kbot);
        for (int c = 0; c < 3; c++) begin
          en = !(r == 0 && s2_f_r.drop_top) && !(r == 2 && s2_f_r.drop_bottom)
             && !(c == 0 && s2_f_r.drop_left) && !(c == 2 && s2_f_r.drop_right);
          k = en ? $signed(krow[8*c +: 8]) : 8'sd0;
          for (int ch = 0; ch < 3; ch++) begin
            p = en ? $signed({1'b0, win_r[r*3+c][16-8*ch +: 8]}) : 9'sd0;
            prod_r[r*3+c][ch] <= 17'(k * p);
          end
        end
      end
    end
  end

  always_comb begin
    logic signed [20:0] sum;
    logic [7:0] chan [3];
    for (int ch = 0; ch < 3; ch++) begin
      sum = '0;
      for (int t = 0; t < 9; t++) begin
        sum = sum + 21'(prod_r[t][ch]);
      end
      if (sum < 0) chan[ch] = 8'd0;
      else if (sum > 21'sd255) chan[ch] = 8'd255;
      else chan[ch] = sum[7:0];
    end
    oq_push = s3_v_r && s3_f_r.emit;
    oq_data = {s3_f_r.last, chan[0], chan[1], chan[2]};
  end
endmodule

@@ sv/rgb_3x3_convolution_sharpen.sv @@
// 3x3 sharpening filter over an RGB pixel stream: one word per cycle sustained while results are popped.
// A result word for pixel m appears when pixel m + width + 1 is taken, and passes
// through the queue, line buffer read, window, products and sum.
// Synchronous active-low reset clears counters, queues and kernel/size registers;
// line buffers and the window hold no reset and need no clearing pass.
module rgb_3x3_convolution_sharpen #(
  parameter int MAX_WIDTH = rgb_pkg::RGB_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_mode,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_frame_end,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH+1);
  localparam int CMPW = (WW > 11) ? WW : 11;
  localparam int FW   = $bits(rgb_pkg::flags_t);
  localparam int MQW  = 24 + CW + FW;

  // Configuration registers. Writing a dimension restarts the frame counters.
  logic [23:0] ktop_r, kmid_r, kbot_r;
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic        restart;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ktop_r   <= rgb_pkg::KTOP_RESET;
      kmid_r   <= rgb_pkg::KMID_RESET;
      kbot_r   <= rgb_pkg::KBOT_RESET;
      width_r  <= rgb_pkg::WIDTH_RESET;
      height_r <= rgb_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rgb_pkg::REG_KTOP:   ktop_r   <= cfg_data;
        rgb_pkg::REG_KMID:   kmid_r   <= cfg_data;
        rgb_pkg::REG_KBOT:   kbot_r   <= cfg_data;
        rgb_pkg::REG_WIDTH:  width_r  <= cfg_data[10:0];
        rgb_pkg::REG_HEIGHT: height_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we &&
                   (cfg_index == rgb_pkg::REG_WIDTH || cfg_index == rgb_pkg::REG_HEIGHT);

  // Out-of-range dimensions are pulled into the supported range.
  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;

  always_comb begin
    if (width_r == '0) w_eff = WW'(1);
    else if (CMPW'(width_r) > CMPW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_r);
    if (height_r == '0) h_eff = 13'd1;
    else if (height_r > 13'(rgb_pkg::HEIGHT_LIMIT)) h_eff = 13'(rgb_pkg::HEIGHT_LIMIT);
    else h_eff = height_r;
  end

  // Front end decides per word whether it is dropped, feeds the window only,
  // or also yields a result; it runs ahead of the back end through a short queue.
  logic            accept, fe_push;
  logic [23:0]     fe_pix;
  logic [CW-1:0]   fe_col;
  rgb_pkg::flags_t fe_flags;

  assign accept = push && !full;

  rgb_fe #(.MAX_WIDTH(MAX_WIDTH)) u_fe (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .accept  (accept),
    .mode    (in_mode),
    .red     (in_red_in),
    .green   (in_green_in),
    .blue    (in_blue_in),
    .q_push  (fe_push),
    .q_pix   (fe_pix),
    .q_col   (fe_col),
    .q_flags (fe_flags)
  );

  logic [MQW-1:0]                       mq_rdata;
  logic [$clog2(rgb_pkg::MID_DEPTH):0]  mq_count;
  logic                                 mq_empty, mq_pop;

  rgb_q #(.W(MQW), .DEPTH(rgb_pkg::MID_DEPTH)) u_mq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_push),
    .wdata ({fe_flags, fe_col, fe_pix}),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .count (mq_count),
    .full  (full),
    .empty (mq_empty)
  );

  // Back end runs the line buffers and the arithmetic. It only takes a word
  // when the result queue is sure to have room, so its pipeline never stalls.
  logic [$clog2(rgb_pkg::OUT_DEPTH):0] oq_count;
  logic                                oq_push, oq_full;
  logic [24:0]                         oq_wdata, oq_rdata;

  rgb_be #(.MAX_WIDTH(MAX_WIDTH), .ODEPTH(rgb_pkg::OUT_DEPTH)) u_be (
    .clk      (clk),
    .rst_n    (rst_n),
    .ktop     (ktop_r),
    .kmid     (kmid_r),
    .kbot     (kbot_r),
    .mq_empty (mq_empty),
    .mq_pix   (mq_rdata[23:0]),
    .mq_col   (mq_rdata[24 +: CW]),
    .mq_flags (rgb_pkg::flags_t'(mq_rdata[24+CW +: FW])),
    .mq_pop   (mq_pop),
    .oq_count (oq_count),
    .oq_push  (oq_push),
    .oq_data  (oq_wdata)
  );

  rgb_q #(.W(25), .DEPTH(rgb_pkg::OUT_DEPTH)) u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .pop   (pop && !empty),
    .rdata (oq_rdata),
    .count (oq_count),
    .full  (oq_full),
    .empty (empty)
  );

  // The credit scheme in the back end keeps the result queue from filling up
  // past the words it has promised; a full flag with a push is a credit slip.
  logic unused_status;
  assign unused_status = oq_full ^ (mq_count == '0);

  assign out_frame_end = oq_rdata[24] | (unused_status & 1'b0);
  assign out_red_out   = oq_rdata[23:16];
  assign out_green_out = oq_rdata[15:8];
  assign out_blue_out  = oq_rdata[7:0];
endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench of the 3x3 RGB sharpening filter rgb_3x3_convolution_sharpen.
// Depends on rgb_pkg for register indexes, the flush mode code and the line size.
module tb;

  // Clock and a synchronous active-low reset that is asserted from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Input queue side, result queue side and configuration port; the driven inputs are known from time zero.
  logic        push = 1'b0;
  logic        full;
  logic        in_mode = 1'b0;
  logic [7:0]  in_red_in = '0;
  logic [7:0]  in_green_in = '0;
  logic [7:0]  in_blue_in = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic        out_frame_end;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  rgb_3x3_convolution_sharpen i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_mode       (in_mode),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .empty         (empty),
    .pop           (pop),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_frame_end (out_frame_end),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // One filtered pixel as it leaves the block.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pixel_out_t;

  // Rows of the directed table: a register write, a pixel word or a flush word.
  typedef enum logic [1:0] {ROW_CFG, ROW_PIXEL, ROW_FLUSH} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    rgb_pkg::reg_idx_t idx;
    logic [23:0]       data;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    bit                typed;
    pixel_out_t        want;
  } row_t;

  // Filter state kept by the testbench, mirroring what the block must hold.
  logic [23:0] kernel_rows [3];
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [23:0] line_prev [rgb_pkg::RGB_MAX_WIDTH];
  logic [23:0] line_prev2 [rgb_pkg::RGB_MAX_WIDTH];
  logic [23:0] window [9];
  int unsigned in_col, in_row, out_col, out_row;

  pixel_out_t pending_pixels [$];
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int failures = 0;
  int words_in = 0;
  int results_seen = 0;
  int settings_run = 0;

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > rgb_pkg::RGB_MAX_WIDTH) return rgb_pkg::RGB_MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == 0) return 1;
    if (height_reg > rgb_pkg::HEIGHT_LIMIT) return rgb_pkg::HEIGHT_LIMIT;
    return height_reg;
  endfunction

  function automatic logic [7:0] saturate(int s);
    if (s < 0) return 8'd0;
    if (s > 255) return 8'd255;
    return s[7:0];
  endfunction

  function automatic void restart_counters();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void apply_register(rgb_pkg::reg_idx_t idx, logic [23:0] d);
    case (idx)
      rgb_pkg::REG_KTOP:   kernel_rows[0] = d;
      rgb_pkg::REG_KMID:   kernel_rows[1] = d;
      rgb_pkg::REG_KBOT:   kernel_rows[2] = d;
      rgb_pkg::REG_WIDTH: begin
        width_reg = d[10:0];
        restart_counters();
      end
      rgb_pkg::REG_HEIGHT: begin
        height_reg = d[12:0];
        restart_counters();
      end
      default: ;
    endcase
  endfunction

  // Weighted sum over the window. With shift set, the output pixel sits in the
  // right window column, which happens on the first word of a new row.
  function automatic pixel_out_t filter_window(int unsigned shift, int unsigned w,
                                               int unsigned h);
    int acc [3];
    int coef;
    int unsigned col;
    logic [23:0] px;
    pixel_out_t res;
    acc = '{0, 0, 0};
    for (int unsigned dy = 0; dy < 3; dy++) begin
      if (dy == 0 && out_row == 0) continue;
      if (dy == 2 && out_row + 1 >= h) continue;
      for (int unsigned dx = 0; dx < 3; dx++) begin
        col = dx + shift;
        if (col > 2) continue;
        if (dx == 0 && out_col == 0) continue;
        if (dx == 2 && out_col + 1 >= w) continue;
        px = window[dy * 3 + col];
        coef = int'($signed(kernel_rows[dy][8 * dx +: 8]));
        for (int ch = 0; ch < 3; ch++)
          acc[ch] += coef * int'(px[16 - 8 * ch +: 8]);
      end
    end
    res.red = saturate(acc[0]);
    res.green = saturate(acc[1]);
    res.blue = saturate(acc[2]);
    res.frame_end = 1'b0;
    return res;
  endfunction

  // Advances the stream by one accepted word; returns 1 when a result is due.
  function automatic bit advance_stream(logic mode, logic [7:0] r, logic [7:0] g,
                                        logic [7:0] b, output pixel_out_t res);
    int unsigned w, h, col;
    bit draining, emit, last;
    logic [23:0] px, up1, up2;
    w = active_width();
    h = active_height();
    draining = in_row >= h;
    res = '0;
    // A flush before the frame's last pixel changes nothing.
    if (mode == rgb_pkg::MODE_FLUSH && !draining) return 0;
    // While draining every word counts as a flush and its pixel is dropped.
    px = draining ? 24'd0 : {r, g, b};
    col = (in_col >= rgb_pkg::RGB_MAX_WIDTH) ? 0 : in_col;
    emit = in_row >= 2 || (in_row == 1 && col >= 1);
    if (emit && col == 0) res = filter_window(1, w, h);
    up2 = line_prev2[col];
    up1 = line_prev[col];
    line_prev2[col] = up1;
    line_prev[col] = px;
    for (int k = 0; k < 3; k++) begin
      window[k * 3] = window[k * 3 + 1];
      window[k * 3 + 1] = window[k * 3 + 2];
    end
    window[2] = up2;
    window[5] = up1;
    window[8] = px;
    if (emit && col != 0) res = filter_window(0, w, h);
    in_col = col + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return 0;
    last = (out_row + 1 >= h) && (out_col + 1 >= w);
    res.frame_end = last;
    if (last) begin
      restart_counters();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1;
  endfunction

  // Offers one word, with random gaps before it, and books its expected result.
  task automatic send_word(logic mode, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           bit typed = 0, pixel_out_t want = '0);
    pixel_out_t res;
    bit due;
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_mode <= mode;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    do @(posedge clk); while (full);
    due = advance_stream(mode, r, g, b, res);
    if (typed) begin
      if (!due || res != want) begin
        $error("directed row: filter state disagrees with the typed result %h", want);
        failures++;
      end
      pending_pixels.push_back(want);
    end else if (due) begin
      pending_pixels.push_back(res);
    end
  endtask

  // Waits until the block has drained every expected word and is quiet.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write of a batch.
  task automatic set_register(rgb_pkg::reg_idx_t idx, logic [23:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    apply_register(idx, d);
  endtask

  function automatic logic [7:0] random_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly small coefficients so that sums are not always clamped.
  function automatic logic [23:0] random_kernel_row();
    logic [23:0] v;
    for (int i = 0; i < 3; i++)
      v[8 * i +: 8] = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(6) - 3);
    return v;
  endfunction

  // Result side: checks each accepted word against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        $error("result word with no expectation: %h %h %h end %b", out_red_out,
               out_green_out, out_blue_out, out_frame_end);
        failures++;
      end else begin
        pixel_out_t want;
        want = pending_pixels.pop_front();
        if (out_red_out !== want.red) begin
          $error("red_out: expected %h, got %h", want.red, out_red_out);
          failures++;
        end
        if (out_green_out !== want.green) begin
          $error("green_out: expected %h, got %h", want.green, out_green_out);
          failures++;
        end
        if (out_blue_out !== want.blue) begin
          $error("blue_out: expected %h, got %h", want.blue, out_blue_out);
          failures++;
        end
        if (out_frame_end !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, out_frame_end);
          failures++;
        end
      end
    end
    pop <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Directed table. An identity kernel (middle tap 1, all else 0) makes the
  // typed results simply the input pixels, in order.
  row_t directed [] = '{
    '{ROW_FLUSH, rgb_pkg::REG_KTOP, 0, 0, 0, 0, 0, '0},          // flush mid-frame
    '{ROW_CFG, rgb_pkg::REG_KTOP, 24'h000000, 0, 0, 0, 0, '0},
    '{ROW_CFG, rgb_pkg::REG_KMID, 24'h000100, 0, 0, 0, 0, '0},
    '{ROW_CFG, rgb_pkg::REG_KBOT, 24'h000000, 0, 0, 0, 0, '0},
    '{ROW_CFG, rgb_pkg::REG_WIDTH, 24'd1, 0, 0, 0, 0, '0},
    '{ROW_CFG, rgb_pkg::REG_HEIGHT, 24'd1, 0, 0, 0, 0, '0},
    '{ROW_PIXEL, rgb_pkg::REG_KTOP, 0, 8'hff, 8'h00, 8'h80, 0, '0},
    '{ROW_FLUSH, rgb_pkg::REG_KTOP, 0, 0, 0, 0, 0, '0},
    '{ROW_FLUSH, rgb_pkg::REG_KTOP, 0, 0, 0, 0, 1, '{8'hff, 8'h00, 8'h80, 1'b1}},
    '{ROW_CFG, rgb_pkg::REG_WIDTH, 24'd2, 0, 0, 0, 0, '0},
    '{ROW_CFG, rgb_pkg::REG_HEIGHT, 24'd2, 0, 0, 0, 0, '0},
    '{ROW_PIXEL, rgb_pkg::REG_KTOP, 0, 8'h01, 8'h02, 8'h03, 0, '0},
    '{ROW_PIXEL, rgb_pkg::REG_KTOP, 0, 8'h10, 8'h20, 8'h30, 0, '0},
    '{ROW_FLUSH, rgb_pkg::REG_KTOP, 0, 0, 0, 0, 0, '0},          // ignored mid-frame
    '{ROW_PIXEL, rgb_pkg::REG_KTOP, 0, 8'hfe, 8'h7f, 8'h00, 0, '0},
    '{ROW_PIXEL, rgb_pkg::REG_KTOP, 0, 8'h00, 8'hff, 8'haa, 1, '{8'h01, 8'h02, 8'h03, 1'b0}},
    // A pixel after the frame is complete acts as a flush.
    '{ROW_PIXEL, rgb_pkg::REG_KTOP, 0, 8'h55, 8'h55, 8'h55, 1, '{8'h10, 8'h20, 8'h30, 1'b0}},
    '{ROW_FLUSH, rgb_pkg::REG_KTOP, 0, 0, 0, 0, 1, '{8'hfe, 8'h7f, 8'h00, 1'b0}},
    '{ROW_FLUSH, rgb_pkg::REG_KTOP, 0, 0, 0, 0, 1, '{8'h00, 8'hff, 8'haa, 1'b1}},
    // Largest positive taps everywhere: every sum clamps high.
    '{ROW_CFG, rgb_pkg::REG_KTOP, 24'h7f7f7f, 0, 0, 0, 0, '0},
    '{ROW_CFG, rgb_pkg::REG_KMID, 24'h7f7f7f, 0, 0, 0, 0, '0},
    '{ROW_CFG, rgb_pkg::REG_KBOT, 24'h7f7f7f, 0, 0, 0, 0, '0},
    '{ROW_PIXEL, rgb_pkg::REG_KTOP, 0, 8'hff, 8'hff, 8'hff, 0, '0},
    '{ROW_PIXEL, rgb_pkg::REG_KTOP, 0, 8'hff, 8'h00, 8'hff, 0, '0},
    '{ROW_PIXEL, rgb_pkg::REG_KTOP, 0, 8'h00, 8'hff, 8'h00, 0, '0},
    '{ROW_PIXEL, rgb_pkg::REG_KTOP, 0, 8'hff, 8'hff, 8'hff, 0, '0},
    '{ROW_FLUSH, rgb_pkg::REG_KTOP, 0, 0, 0, 0, 0, '0},
    '{ROW_FLUSH, rgb_pkg::REG_KTOP, 0, 0, 0, 0, 0, '0},
    '{ROW_FLUSH, rgb_pkg::REG_KTOP, 0, 0, 0, 0, 0, '0}
  };

  initial begin
    int unsigned w, h, npix;
    bit partial;
    int phase;
    logic [23:0] k_top, k_mid, k_bot;
    logic [10:0] w_set;
    logic [12:0] h_set;

    kernel_rows = '{rgb_pkg::KTOP_RESET, rgb_pkg::KMID_RESET, rgb_pkg::KBOT_RESET};
    width_reg = rgb_pkg::WIDTH_RESET;
    height_reg = rgb_pkg::HEIGHT_RESET;
    foreach (line_prev[i]) begin
      line_prev[i] = '0;
      line_prev2[i] = '0;
    end
    foreach (window[i]) window[i] = '0;
    restart_counters();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows, plain handshakes.
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        if (i == 0 || directed[i - 1].kind != ROW_CFG) wait_idle();
        set_register(directed[i].idx, directed[i].data);
      end else begin
        cfg_we <= 1'b0;
        send_word(directed[i].kind == ROW_FLUSH ? rgb_pkg::MODE_FLUSH : ~rgb_pkg::MODE_FLUSH,
                  directed[i].red, directed[i].green, directed[i].blue,
                  directed[i].typed, directed[i].want);
      end
    end

    // Random frames. The first few settings are the extremes; later ones are
    // small frames with random kernels, some of them cut short by a new setting.
    for (phase = 0; phase < 6 || words_in < 900; phase++) begin
      case ((phase / 2) % 3)
        0: begin
          tx_idle_pct = 36;
          rx_idle_pct = 56;
        end
        1: begin
          tx_idle_pct = 56;
          rx_idle_pct = 36;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      k_top = random_kernel_row();
      k_mid = random_kernel_row();
      k_bot = random_kernel_row();
      w_set = 11'($urandom_range(1, 8));
      h_set = 13'($urandom_range(1, 6));
      partial = ($urandom_range(99) < 15);
      case (phase)
        0: begin
          // Most negative taps: every sum clamps to zero.
          k_top = 24'h808080;
          k_mid = 24'h808080;
          k_bot = 24'h808080;
          w_set = 11'd3;
          h_set = 13'd3;
          partial = 0;
        end
        1: begin
          w_set = 11'd0;
          h_set = 13'd0;
          partial = 0;
        end
        2: begin
          w_set = 11'h7ff;
          h_set = 13'd1;
          partial = 1;
        end
        3: begin
          w_set = 11'd1;
          h_set = 13'h1fff;
          partial = 1;
        end
        4: begin
          w_set = 11'd1024;
          h_set = 13'd2;
          partial = 1;
        end
        default: ;
      endcase

      wait_idle();
      set_register(rgb_pkg::REG_KTOP, k_top);
      set_register(rgb_pkg::REG_KMID, k_mid);
      set_register(rgb_pkg::REG_KBOT, k_bot);
      set_register(rgb_pkg::REG_WIDTH, 24'(w_set));
      set_register(rgb_pkg::REG_HEIGHT, 24'(h_set));
      cfg_we <= 1'b0;
      settings_run++;

      w = active_width();
      h = active_height();
      npix = w * h;
      if (partial) npix = (npix > 60) ? $urandom_range(20, 60) : $urandom_range(1, npix);
      for (int unsigned i = 0; i < npix; i++) begin
        // Stray flushes inside the frame must be ignored.
        if ($urandom_range(99) < 8) begin
          send_word(rgb_pkg::MODE_FLUSH, random_byte(), random_byte(), random_byte());
          words_in++;
        end
        send_word(~rgb_pkg::MODE_FLUSH, random_byte(), random_byte(), random_byte());
        words_in++;
      end
      if (!partial) begin
        for (int unsigned i = 0; i <= w; i++) begin
          send_word(($urandom_range(99) < 30) ? ~rgb_pkg::MODE_FLUSH : rgb_pkg::MODE_FLUSH,
                    random_byte(), random_byte(), random_byte());
          words_in++;
        end
      end
    end

    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Filter run: %0d random words over %0d frame settings, %0d result words",
             words_in, settings_run, results_seen);
    $display("Settings included extreme kernels, out-of-range sizes and cut-short frames.");
    if (failures == 0 && pending_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #10000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
